// ----- rtl/core/hcbd_pkg.sv -----
// Package for the HTTP chunked body decoder.
// Holds the decoder state types, character codes and the hex digit decode.
// No dependencies.
`default_nettype none

package hcbd_pkg;

    localparam int unsigned SizeW  = 31;
    localparam int unsigned TotalW = 32;
    localparam int unsigned DigitW = 4;

    localparam logic [DigitW-1:0] MAX_SIZE_DIGITS = 4'd8;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [SizeW-1:0] BODY_LIMIT_RESET = 31'd1048576;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_DATA,
        PH_DEND,
        PH_FINAL
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2,
        ST_BIG  = 2'd3
    } t_status;

    typedef struct packed {
        t_phase              phase;
        logic [SizeW-1:0]    size_accum;
        logic [DigitW-1:0]   digit_count;
        logic [SizeW-1:0]    chunk_rem;
        logic                pending_cr;
        logic [TotalW-1:0]   total_bytes;
        t_status             status;
    } t_body_state;

    localparam t_body_state BODY_CLEAR = '{
        phase:       PH_SIZE,
        size_accum:  '0,
        digit_count: '0,
        chunk_rem:   '0,
        pending_cr:  1'b0,
        total_bytes: '0,
        status:      ST_RUN
    };

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        t_status    status;
    } t_result;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/http_chunked_body_decoder.sv -----
// Top level of the HTTP chunked body decoder: stream ports, state and output registers.
// Uses hcbd_pkg and hcbd_step.
//
// Takes one raw body byte per clock and returns exactly one result word per
// byte, in the cycle after it is accepted: a payload flag, the payload byte (zero
// when not payload) and the body status (in progress, complete, malformed, too
// large; errors and completion stick until a byte arrives with new_body set).
// The whole per-byte update is combinational logic into the state registers,
// and a one-word output register decouples the two sides, so the block sustains
// one byte per clock whenever the sink takes a word every cycle. body_limit may
// only be written while no byte is in flight.
`default_nettype none

module http_chunked_body_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [30:0] i_cfg_wr_data,   // body_limit
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  wire logic [0:0]  s_axis_tuser,    // [0] new_body
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,    // [7:0] data_byte
    output      logic [2:0]  m_axis_tuser     // [0] data_valid, [2:1] status
);

    logic [hcbd_pkg::SizeW-1:0] r_body_limit;
    hcbd_pkg::t_body_state      r_state;
    hcbd_pkg::t_body_state      n_state;
    hcbd_pkg::t_result          n_result;
    logic                       r_out_valid;
    logic [7:0]                 r_out_data;
    logic [2:0]                 r_out_user;
    logic                       in_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    hcbd_step u_step (
        .i_state      (r_state),
        .i_byte       (s_axis_tdata),
        .i_new_body   (s_axis_tuser[0]),
        .i_body_limit (r_body_limit),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_limit <= hcbd_pkg::BODY_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_body_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcbd_pkg::BODY_CLEAR;
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_result.data_byte;
            r_out_user <= {n_result.status, n_result.data_valid};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ----- rtl/core/hcbd_step.sv -----
// Per-byte next-state and result logic of the chunked body decoder.
// Purely combinational; uses hcbd_pkg.
`default_nettype none

module hcbd_step (
    input  wire hcbd_pkg::t_body_state         i_state,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_new_body,
    input  wire logic [hcbd_pkg::SizeW-1:0]    i_body_limit,
    output hcbd_pkg::t_body_state              o_state,
    output hcbd_pkg::t_result                  o_result
);

    hcbd_pkg::t_body_state cur;
    hcbd_pkg::t_body_state nxt;
    logic [4:0]            hex;
    logic [hcbd_pkg::SizeW-1:0] rem_dec;
    logic                  valid;

    assign hex     = hcbd_pkg::hex_decode(i_byte);

    always_comb begin
        cur     = i_new_body ? hcbd_pkg::BODY_CLEAR : i_state;
        rem_dec = cur.chunk_rem - 1'b1;
        nxt     = cur;
        valid   = 1'b0;

        if (cur.status == hcbd_pkg::ST_RUN) begin
            unique case (cur.phase)
                hcbd_pkg::PH_SIZE: begin
                    if (cur.pending_cr) begin
                        if (i_byte == hcbd_pkg::CHAR_LF) begin
                            // size line done
                            nxt.pending_cr = 1'b0;
                            if (cur.digit_count == '0) begin
                                nxt.status = hcbd_pkg::ST_DONE;
                            end else if (cur.size_accum == '0) begin
                                nxt.phase = hcbd_pkg::PH_FINAL;
                            end else begin
                                nxt.chunk_rem = cur.size_accum;
                                nxt.phase     = hcbd_pkg::PH_DATA;
                            end
                            nxt.size_accum  = '0;
                            nxt.digit_count = '0;
                        end else begin
                            nxt.status = hcbd_pkg::ST_BAD;
                        end
                    end else if (i_byte == hcbd_pkg::CHAR_CR) begin
                        nxt.pending_cr = 1'b1;
                    end else if (i_byte == hcbd_pkg::CHAR_SEMI) begin
                        if (cur.digit_count == '0) nxt.status = hcbd_pkg::ST_BAD;
                        else                       nxt.phase  = hcbd_pkg::PH_EXT;
                    end else if (!hex[4] || cur.digit_count >= hcbd_pkg::MAX_SIZE_DIGITS
                                 || cur.size_accum[30:27] != 4'd0) begin
                        nxt.status = hcbd_pkg::ST_BAD;
                    end else begin
                        nxt.size_accum  = {cur.size_accum[26:0], hex[3:0]};
                        nxt.digit_count = cur.digit_count + 1'b1;
                    end
                end
                hcbd_pkg::PH_EXT: begin
                    if (cur.pending_cr && i_byte == hcbd_pkg::CHAR_LF) begin
                        nxt.pending_cr  = 1'b0;
                        nxt.size_accum  = '0;
                        nxt.digit_count = '0;
                        // extension only follows a digit, so digit_count is nonzero
                        if (cur.size_accum == '0) begin
                            nxt.phase = hcbd_pkg::PH_FINAL;
                        end else begin
                            nxt.chunk_rem = cur.size_accum;
                            nxt.phase     = hcbd_pkg::PH_DATA;
                        end
                    end else begin
                        nxt.pending_cr = (i_byte == hcbd_pkg::CHAR_CR);
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    if (cur.pending_cr && i_byte == hcbd_pkg::CHAR_LF) begin
                        nxt.status = hcbd_pkg::ST_BAD;
                    end else begin
                        valid          = 1'b1;
                        nxt.pending_cr = (i_byte == hcbd_pkg::CHAR_CR);
                        if (cur.total_bytes != '1) nxt.total_bytes = cur.total_bytes + 1'b1;
                        nxt.chunk_rem = rem_dec;
                        if (rem_dec == '0) begin
                            nxt.phase      = hcbd_pkg::PH_DEND;
                            nxt.pending_cr = 1'b0;
                        end
                    end
                end
                hcbd_pkg::PH_DEND: begin
                    if (!cur.pending_cr) begin
                        if (i_byte == hcbd_pkg::CHAR_CR) nxt.pending_cr = 1'b1;
                        else                             nxt.status     = hcbd_pkg::ST_BAD;
                    end else if (i_byte != hcbd_pkg::CHAR_LF) begin
                        nxt.status = hcbd_pkg::ST_BAD;
                    end else begin
                        nxt.pending_cr = 1'b0;
                        if (cur.total_bytes > {1'b0, i_body_limit}) begin
                            nxt.status = hcbd_pkg::ST_BIG;
                        end else begin
                            nxt.phase       = hcbd_pkg::PH_SIZE;
                            nxt.size_accum  = '0;
                            nxt.digit_count = '0;
                        end
                    end
                end
                hcbd_pkg::PH_FINAL: begin
                    if (cur.pending_cr && i_byte == hcbd_pkg::CHAR_LF) begin
                        nxt.pending_cr = 1'b0;
                        nxt.status     = hcbd_pkg::ST_DONE;
                    end else begin
                        nxt.pending_cr = (i_byte == hcbd_pkg::CHAR_CR);
                    end
                end
                default: begin
                    nxt.status = hcbd_pkg::ST_BAD;
                end
            endcase
        end

        if (nxt.status == hcbd_pkg::ST_BAD || nxt.status == hcbd_pkg::ST_BIG) valid = 1'b0;

        o_state             = nxt;
        o_result.data_valid = valid;
        o_result.data_byte  = valid ? i_byte : 8'd0;
        o_result.status     = nxt.status;
    end

endmodule

`default_nettype wire

// ----- rtl/core/hcbd_chk.sv -----
// Port-level checker for http_chunked_body_decoder, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module hcbd_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // after reset the output is empty and the input side is open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("output not empty after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

    // no payload byte alongside an error status
    a_no_data_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[2])
        else $error("payload flagged with error status");

    // non-payload words carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("nonzero byte in non-payload word");

    // an accepted byte always yields a word next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted byte produced no word");

endmodule

bind http_chunked_body_decoder hcbd_chk u_hcbd_chk (.*);

`default_nettype wire

// ----- tb/sv/chunked_decode_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the chunked body decoder bench: mirrors the decoder state per input
// word, queues the predicted result words and compares them with the output stream.
// Depends on hcbd_pkg for the phase/status types, character codes and reset limit.
module chunked_decode_checker
    import hcbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] in_byte
    input  logic [0:0]  i_s_tuser,      // [0] new_body
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,      // [7:0] data_byte
    input  logic [2:0]  i_m_tuser,      // [0] data_valid, [2:1] status
    output int          o_fail_count,
    output int          o_pending
);

    // mirrored decoder state
    logic [30:0] body_lim;
    t_phase      ph;
    logic [31:0] size_acc;
    logic [3:0]  ndigits;
    logic [30:0] chunk_left;
    logic        cr_seen;
    logic [31:0] payload_total;
    t_status     body_status;

    t_result     awaited_results[$];
    t_result     want;
    logic        word_ok;
    int          mismatch_count = 0;

    function automatic void clear_body();
        ph            = PH_SIZE;
        size_acc      = '0;
        ndigits       = '0;
        chunk_left    = '0;
        cr_seen       = 1'b0;
        payload_total = '0;
        body_status   = ST_RUN;
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    // CR LF closed the size line (or its extension)
    function automatic void close_size_line();
        cr_seen = 1'b0;
        if (ndigits == 0) begin
            body_status = ST_DONE;
        end else if (size_acc == 0) begin
            ph = PH_FINAL;
        end else begin
            chunk_left = size_acc[30:0];
            ph = PH_DATA;
        end
        size_acc = '0;
        ndigits  = '0;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b, input logic restart);
        t_result r;
        int      d;
        r.data_valid = 1'b0;
        r.data_byte  = 8'h00;
        r.status     = ST_RUN;
        if (restart) clear_body();
        if (body_status == ST_RUN) begin
            case (ph)
                PH_SIZE: begin
                    if (cr_seen) begin
                        if (b == CHAR_LF) close_size_line();
                        else body_status = ST_BAD;
                    end else if (b == CHAR_CR) begin
                        cr_seen = 1'b1;
                    end else if (b == CHAR_SEMI) begin
                        if (ndigits == 0) body_status = ST_BAD;
                        else ph = PH_EXT;
                    end else begin
                        d = hex_digit(b);
                        // reject bad chars, a ninth digit, and sizes past 2^31-1
                        if (d < 0 || ndigits >= MAX_SIZE_DIGITS || size_acc > 32'h07FF_FFFF) begin
                            body_status = ST_BAD;
                        end else begin
                            size_acc = {size_acc[27:0], d[3:0]};
                            ndigits  = ndigits + 4'd1;
                        end
                    end
                end
                PH_EXT: begin
                    if (cr_seen && b == CHAR_LF) close_size_line();
                    else cr_seen = (b == CHAR_CR);
                end
                PH_DATA: begin
                    if (cr_seen && b == CHAR_LF) begin
                        body_status = ST_BAD;
                    end else begin
                        cr_seen      = (b == CHAR_CR);
                        r.data_valid = 1'b1;
                        r.data_byte  = b;
                        if (payload_total != 32'hFFFF_FFFF) payload_total = payload_total + 32'd1;
                        chunk_left = chunk_left - 31'd1;
                        if (chunk_left == 0) begin
                            ph      = PH_DEND;
                            cr_seen = 1'b0;
                        end
                    end
                end
                PH_DEND: begin
                    if (!cr_seen) begin
                        if (b == CHAR_CR) cr_seen = 1'b1;
                        else body_status = ST_BAD;
                    end else if (b != CHAR_LF) begin
                        body_status = ST_BAD;
                    end else begin
                        cr_seen = 1'b0;
                        if (payload_total > {1'b0, body_lim}) begin
                            body_status = ST_BIG;
                        end else begin
                            ph       = PH_SIZE;
                            size_acc = '0;
                            ndigits  = '0;
                        end
                    end
                end
                PH_FINAL: begin
                    if (cr_seen && b == CHAR_LF) begin
                        cr_seen     = 1'b0;
                        body_status = ST_DONE;
                    end else begin
                        cr_seen = (b == CHAR_CR);
                    end
                end
                default: begin
                    body_status = ST_BAD;
                end
            endcase
        end
        if (body_status == ST_BAD || body_status == ST_BIG) begin
            r.data_valid = 1'b0;
            r.data_byte  = 8'h00;
        end
        r.status = body_status;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_body();
            body_lim = BODY_LIMIT_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg_wr_en) body_lim = i_cfg_wr_data;
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("output word with nothing awaited: tdata %02h tuser %03b",
                           i_m_tdata, i_m_tuser);
                    mismatch_count++;
                end else begin
                    want    = awaited_results.pop_front();
                    word_ok = 1'b1;
                    if (i_m_tuser[0] !== want.data_valid) begin
                        $error("data_valid: expected %0d, got %0d", want.data_valid, i_m_tuser[0]);
                        word_ok = 1'b0;
                    end
                    if (i_m_tdata !== want.data_byte) begin
                        $error("data_byte: expected %02h, got %02h", want.data_byte, i_m_tdata);
                        word_ok = 1'b0;
                    end
                    if (i_m_tuser[2:1] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser[2:1]);
                        word_ok = 1'b0;
                    end
                    if (!word_ok) mismatch_count++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(decode_byte(i_s_tdata, i_s_tuser[0]));
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= awaited_results.size();
    end

endmodule

// ----- tb/sv/tb_http_chunked_body_decoder.sv -----
`timescale 1ns / 1ps
// Top of the chunked body decoder bench: clock, reset, body_limit writes and byte stimulus
// (well-formed and broken chunked bodies), with random source gaps and sink stalls.
// Depends on hcbd_pkg, http_chunked_body_decoder and chunked_decode_checker.
module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_SIZE_CHAR,
        FLAW_SEMI_FIRST,
        FLAW_DIGITS,
        FLAW_OVERFLOW,
        FLAW_LONE_CR,
        FLAW_DATA_CRLF,
        FLAW_DATA_END,
        FLAW_CUT
    } t_flaw;

    localparam int NumPhases   = 6;
    localparam int PhaseBytes  = 135;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [30:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] in_byte
    logic [0:0]  s_axis_tuser  = '0;     // [0] new_body
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] data_byte
    logic [2:0]  m_axis_tuser;           // [0] data_valid, [2:1] status

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    logic [7:0] run_bytes[$];

    int          send_idle_tab[4] = '{0, 52, 0, 35};
    int          stall_tab[4]     = '{0, 0, 52, 35};
    logic [30:0] limit_tab[NumPhases] = '{31'd0, 31'h7FFF_FFFF, 31'd25, 31'd1, 31'd300, 31'd120};

    always #2 i_clk = ~i_clk;

    http_chunked_body_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    chunked_decode_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #2_000_000;
        $display("tb_http_chunked_body_decoder: FAIL");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (($urandom_range(1) == 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
    endfunction

    function automatic int hex_width(input logic [31:0] v);
        int n;
        n = 1;
        while (n < 8 && (v >> (4 * n)) != 0) n++;
        return n;
    endfunction

    function automatic void put_digits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) run_bytes.push_back(hex_char(v[4*i +: 4]));
    endfunction

    function automatic void put_crlf();
        run_bytes.push_back(CHAR_CR);
        run_bytes.push_back(CHAR_LF);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) run_bytes.push_back(s[i]);
    endfunction

    // random bytes, CR-heavy, that never form a CR LF pair
    function automatic void put_filler(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(7) == 0) ? CHAR_CR : 8'($urandom_range(255));
            if (c == CHAR_LF && run_bytes.size() != 0 && run_bytes[$] == CHAR_CR) c = CHAR_SEMI;
            run_bytes.push_back(c);
        end
    endfunction

    function automatic void put_size_line(input logic [31:0] size);
        int n;
        n = hex_width(size);
        if ($urandom_range(3) == 0) n = $urandom_range(n, 8);
        put_digits(size, n);
        if ($urandom_range(3) == 0) begin
            run_bytes.push_back(CHAR_SEMI);
            put_filler($urandom_range(0, 5));
        end
        put_crlf();
    endfunction

    function automatic void put_flaw(input t_flaw flaw, input int size);
        logic [7:0] c;
        case (flaw)
            FLAW_SIZE_CHAR: begin
                put_digits($urandom, $urandom_range(0, 2));
                c = ($urandom_range(1) == 1) ? 8'($urandom_range(8'h67, 8'hFF))
                                             : 8'($urandom_range(8'h0E, 8'h2F));
                run_bytes.push_back(c);
            end
            FLAW_SEMI_FIRST: begin
                run_bytes.push_back(CHAR_SEMI);
            end
            FLAW_DIGITS: begin
                put_digits(32'd0, 2);
                put_digits($urandom, 7);
            end
            FLAW_OVERFLOW: begin
                put_digits({1'b1, 31'($urandom)}, 8);
            end
            FLAW_LONE_CR: begin
                put_digits(size, hex_width(size));
                run_bytes.push_back(CHAR_CR);
                c = 8'($urandom_range(255));
                if (c == CHAR_LF) c = CHAR_CR;
                run_bytes.push_back(c);
            end
            FLAW_DATA_CRLF: begin
                put_size_line(size + 2);
                put_filler($urandom_range(0, size));
                put_crlf();
            end
            FLAW_DATA_END: begin
                put_size_line(size);
                put_filler(size);
                if ($urandom_range(1) == 1) begin
                    c = 8'($urandom_range(255));
                    if (c == CHAR_CR) c = CHAR_LF;
                    run_bytes.push_back(c);
                end else begin
                    run_bytes.push_back(CHAR_CR);
                    c = 8'($urandom_range(255));
                    if (c == CHAR_LF) c = 8'h00;
                    run_bytes.push_back(c);
                end
            end
            default: begin
                // body cut short; a huge declared chunk is never finished
                if ($urandom_range(2) == 0) begin
                    put_size_line(32'h7FFF_FFFF);
                    put_filler($urandom_range(0, 6));
                end else begin
                    put_size_line(size);
                    put_filler($urandom_range(0, size - 1));
                end
            end
        endcase
    endfunction

    function automatic void build_body(input t_flaw flaw);
        int nchunks;
        int flaw_at;
        int size;
        nchunks = $urandom_range(0, 3);
        flaw_at = $urandom_range(0, nchunks);
        for (int c = 0; c <= nchunks; c++) begin
            if (c == nchunks) size = 0;
            else if ($urandom_range(7) == 0) size = $urandom_range(9, 48);
            else size = $urandom_range(1, 8);
            if (flaw != FLAW_NONE && c == flaw_at) begin
                put_flaw(flaw, (size == 0) ? 1 : size);
                break;
            end
            if (size == 0 && $urandom_range(3) == 0) begin
                put_crlf();     // empty size line ends the body
            end else if (size == 0) begin
                put_size_line(32'd0);
                put_filler($urandom_range(0, 4));
                put_crlf();
            end else begin
                put_size_line(size);
                put_filler(size);
                put_crlf();
            end
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic nb);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= nb;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // first word of a run carries new_body
    task automatic send_run();
        foreach (run_bytes[i]) send_word(run_bytes[i], i == 0);
        run_bytes.delete();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [30:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int    body_bytes;
        int    pick;
        t_flaw flaw;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one full body with extension and sticky completion, then an empty body and short faults
        put_text("1;x");
        put_crlf();
        run_bytes.push_back(8'h00);
        put_crlf();
        put_text("0");
        put_crlf();
        put_crlf();
        run_bytes.push_back(8'hFF);
        send_run();
        run_bytes.push_back(CHAR_SEMI);
        send_run();
        put_crlf();
        send_run();
        put_text("3");
        put_crlf();
        put_crlf();
        send_run();
        put_text("Fg");
        send_run();
        wait_drained();

        for (int p = 0; p < NumPhases; p++) begin
            write_limit(limit_tab[p]);
            idle_pct   = send_idle_tab[p % 4];
            stall_pct  = stall_tab[p % 4];
            body_bytes = 0;
            while (body_bytes < PhaseBytes) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
                    end
                end else begin
                    flaw = (pick < 70) ? FLAW_NONE
                                       : t_flaw'($urandom_range(FLAW_CUT, FLAW_SIZE_CHAR));
                    build_body(flaw);
                    repeat ($urandom_range(0, 2)) run_bytes.push_back(8'($urandom_range(255)));
                    body_bytes += run_bytes.size();
                    send_run();
                end
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_http_chunked_body_decoder: PASS");
        end else begin
            $display("tb_http_chunked_body_decoder: FAIL");
        end
        $finish;
    end

endmodule
